// ===== src/u8l1_pkg.sv =====
// Package for the UTF-8 to single-byte decoder.
// Holds the transfer payload types, register indexes and decode constants.
// Depends on nothing; imported by utf8_to_latin1_decoder_unit.
package u8l1_pkg;

    // Widths of the fixed fields.
    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 21;
    localparam int REMAIN_W    = 2;
    localparam int CFG_INDEX_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_CHAR = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_CODE_POINT   = 4'd1;

    // Register reset values.
    localparam logic [BYTE_W-1:0] REPLACEMENT_RESET = 8'd63;
    localparam logic [BYTE_W-1:0] MAX_CODE_RESET    = 8'hff;

    // Lead byte thresholds.
    localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hc0;

    // Continuation bytes still expected after each kind of lead.
    localparam logic [REMAIN_W-1:0] REMAIN_NONE  = 2'd0;
    localparam logic [REMAIN_W-1:0] REMAIN_LEAD2 = 2'd1;
    localparam logic [REMAIN_W-1:0] REMAIN_LEAD3 = 2'd2;
    localparam logic [REMAIN_W-1:0] REMAIN_LEAD4 = 2'd3;

    // One input byte of the stream.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              last_byte;
    } dec_in_t;

    // One decoded character.
    typedef struct packed {
        logic [BYTE_W-1:0] char_out;
        logic              end_of_string;
    } dec_out_t;

endpackage

// ===== src/utf8_to_latin1_decoder_unit.sv =====
// Top level of the UTF-8 to single-byte decoder: sequence state, decode and
// the result register. Depends on u8l1_pkg for payload types and constants.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+--------------------------------------
//  input    | in_valid / in_ready   | in_item  (byte_in, last_byte)
//  output   | out_valid / out_ready | out_item (char_out, end_of_string)
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each byte is decoded on the transfer and its character, if any, sits in the
// result register from the next cycle on.
// One byte per cycle is sustained while the output side takes every result.
// in_ready is low only while a result is held and out_ready is low.
// Reset clears the open sequence and result valid flag, presets both config
// registers; the result data is loaded before it is first marked valid.
module utf8_to_latin1_decoder_unit
    import u8l1_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  dec_in_t                in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output dec_out_t               out_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data
);

    logic [BYTE_W-1:0]   repl_reg;
    logic [BYTE_W-1:0]   max_code_reg;
    logic [REMAIN_W-1:0] remain_reg;
    logic [REMAIN_W-1:0] remain_next;
    logic [CODE_W-1:0]   acc_reg;
    logic [CODE_W-1:0]   acc_next;
    logic                out_valid_reg;
    dec_out_t            out_item_reg;
    logic                emit;
    dec_out_t            result;
    logic [CODE_W-1:0]   code_point;
    logic [CODE_W-1:0]   shifted;
    logic                in_xfer;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg     <= REPLACEMENT_RESET;
            max_code_reg <= MAX_CODE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REPLACEMENT_CHAR: repl_reg     <= cfg_data;
                CFG_MAX_CODE_POINT:   max_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A new byte is taken whenever the result register is free or draining.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Accumulator with the six data bits of this byte appended.
    assign shifted = {acc_reg[CODE_W-7:0], in_item.byte_in[5:0]};

    // Decode one byte against the open sequence.
    always_comb
    begin
        remain_next   = remain_reg;
        acc_next      = acc_reg;
        emit          = 1'b0;
        code_point    = {{(CODE_W-BYTE_W){1'b0}}, in_item.byte_in};
        if (remain_reg == REMAIN_NONE)
        begin
            if (in_item.byte_in >= LEAD4_MIN)
            begin
                acc_next    = {{(CODE_W-3){1'b0}}, in_item.byte_in[2:0]};
                remain_next = REMAIN_LEAD4;
            end
            else if (in_item.byte_in >= LEAD3_MIN)
            begin
                acc_next    = {{(CODE_W-4){1'b0}}, in_item.byte_in[3:0]};
                remain_next = REMAIN_LEAD3;
            end
            else if (in_item.byte_in >= LEAD2_MIN)
            begin
                acc_next    = {{(CODE_W-6){1'b0}}, in_item.byte_in[5:0]};
                remain_next = REMAIN_LEAD2;
            end
            else
            begin
                emit = 1'b1;
            end
        end
        else
        begin
            remain_next = remain_reg - REMAIN_LEAD2;
            acc_next    = shifted;
            if (remain_reg == REMAIN_LEAD2)
            begin
                code_point = shifted;
                acc_next   = '0;
                emit       = 1'b1;
            end
        end

        // Full code point is compared before it is narrowed to a byte.
        if (code_point > {{(CODE_W-BYTE_W){1'b0}}, max_code_reg})
            result.char_out = repl_reg;
        else
            result.char_out = code_point[BYTE_W-1:0];
        result.end_of_string = in_item.last_byte;

        // A string that ends inside a sequence gives one replacement character.
        if (!emit && in_item.last_byte)
        begin
            remain_next     = REMAIN_NONE;
            acc_next        = '0;
            emit            = 1'b1;
            result.char_out = repl_reg;
        end
    end

    // Sequence state advances on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= REMAIN_NONE;
            acc_reg    <= '0;
        end
        else if (in_xfer)
        begin
            remain_reg <= remain_next;
            acc_reg    <= acc_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_xfer && emit;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // No open sequence means an empty accumulator.
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg == REMAIN_NONE |-> acc_reg == '0)
        else $error("accumulator holds bits with no sequence open");

    // The last byte of a string always closes the sequence.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_item.last_byte |=> remain_reg == REMAIN_NONE)
        else $error("sequence still open after the last byte");

    // The last byte of a string always yields a final character.
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_item.last_byte |=> out_valid && out_item.end_of_string)
        else $error("last byte gave no end-of-string character");

    // A held result blocks new input.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while a result is stalled");

endmodule
